// ----- rtl/pvm_pkg.sv -----
// Package for the PCM voice mixer: constants, item kinds, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvm_pkg;
  localparam int VOICES_DEF = 8;
  localparam int SAMPLE_ADDR_BITS_DEF = 16;
  localparam logic [15:0] FPB_RESET = 16'd256;
  localparam logic [17:0] POS_MAX = 18'h3FFFF;

  typedef enum logic [2:0] {
    KIND_TICK = 3'd0,
    KIND_LOAD = 3'd1,
    KIND_PLAY = 3'd2,
    KIND_END  = 3'd3,
    KIND_ENDALL = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAY_SCAN,
    ST_TICK_RD,
    ST_TICK_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [16:0] length;
    logic        loop_flag;
    logic        concurrent_flag;
    logic [15:0] load_left;
    logic [15:0] load_right;
  } item_t;

  typedef struct packed {
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic        buffer_end;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/pvm_if.sv -----
// Valid/ready channel carrying one payload struct.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface pvm_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/pvm_sample_ram.sv -----
// Sample RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module pvm_sample_ram #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [31:0]          wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic [31:0]               rdata
);
  logic [31:0] mem [2**ADDR_BITS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/pcm_voice_mixer.sv -----
// Eight-voice stereo PCM mixer over an internal sample RAM. Load and end items complete as
// they are accepted. A play scans the voices one per cycle, and the next item can enter
// once the scan is done. A tick visits each voice in turn through ST_TICK_RD and
// ST_TICK_MIX using the single RAM read port, and its result is registered in ST_OUT
// after the last voice. The RAM is not cleared; read only written frames. The input is held
// off while a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module pcm_voice_mixer
  import pvm_pkg::*;
#(
  parameter int VOICES = VOICES_DEF,
  parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pvm_if.sink        in_ch,
  pvm_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AB = SAMPLE_ADDR_BITS;

  state_t state, state_next;
  item_t  it;
  logic [15:0] fpb, frame_count;
  logic [VB:0] vi;
  logic [15:0] base [VOICES];
  logic [16:0] len [VOICES];
  logic [17:0] pos [VOICES];
  logic        loopv [VOICES], ending [VOICES], ml [VOICES], mr [VOICES];
  logic signed [15:0] pl [VOICES], pr [VOICES];
  logic [15:0] mix_l, mix_r;
  logic        blocked, found;
  logic [VB-1:0] free_idx;
  logic        out_valid;
  result_t     out_data;

  logic [AB-1:0] raddr;
  logic [31:0]   rdata;
  logic          act_q;
  logic [VB-1:0] cur;

  assign cur = vi[VB-1:0];

  pvm_sample_ram #(.ADDR_BITS(AB)) u_ram (
    .clk, .we(in_ch.valid && in_ch.ready && in_ch.data.kind == KIND_LOAD),
    .waddr(AB'(in_ch.data.address)),
    .wdata({in_ch.data.load_right, in_ch.data.load_left}),
    .raddr, .rdata
  );

  logic [17:0] pos_eff;
  logic        active;
  always_comb begin
    pos_eff = (loopv[cur] && pos[cur] >= {1'b0, len[cur]}) ? '0 : pos[cur];
    active = len[cur] != 0 && pos_eff < {1'b0, len[cur]};
    raddr = AB'(base[cur] + pos_eff[15:0]);
    if (AB > 16) raddr = AB'({2'b0, base[cur]} + pos_eff);
  end

  assign in_ch.ready = (state == ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.kind == KIND_PLAY) state_next = ST_PLAY_SCAN;
        else if (in_ch.data.kind == KIND_TICK) state_next = ST_TICK_RD;
      end
      ST_PLAY_SCAN: if (vi == (VB+1)'(VOICES)) state_next = ST_IDLE;
      ST_TICK_RD: state_next = ST_TICK_MIX;
      ST_TICK_MIX: state_next = (vi == (VB+1)'(VOICES - 1)) ? ST_OUT : ST_TICK_RD;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic last;
  assign last = (32'(frame_count) + 1) >= 32'(fpb);

  logic signed [15:0] cl, cr;
  logic nml, nmr;
  always_comb begin
    cl = rdata[15:0];
    cr = rdata[31:16];
    nml = ml[cur] || (ending[cur] && !cl[15] && (pl[cur] <= 0));
    nmr = mr[cur] || (ending[cur] && !cr[15] && (pr[cur] <= 0));
    if (nml) cl = '0;
    if (nmr) cr = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fpb <= FPB_RESET;
      frame_count <= '0;
      out_valid <= 1'b0;
      vi <= '0;
      for (int j = 0; j < VOICES; j++) begin
        base[j] <= '0; len[j] <= '0; pos[j] <= '0; loopv[j] <= 1'b0;
        ending[j] <= 1'b0; ml[j] <= 1'b0; mr[j] <= 1'b0; pl[j] <= '0; pr[j] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) fpb <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          it <= in_ch.data;
          vi <= '0;
          blocked <= 1'b0;
          found <= 1'b0;
          free_idx <= '0;
          mix_l <= '0;
          mix_r <= '0;
          if (in_ch.data.kind == KIND_END || in_ch.data.kind == KIND_ENDALL) begin
            for (int j = 0; j < VOICES; j++)
              if (in_ch.data.kind == KIND_ENDALL || base[j] == in_ch.data.address)
                ending[j] <= len[j] != 0;
          end
        end
        ST_PLAY_SCAN: begin
          if (vi == (VB+1)'(VOICES)) begin
            if (!blocked && found && it.length != 0) begin
              base[free_idx] <= it.address; len[free_idx] <= it.length;
              pos[free_idx] <= '0; loopv[free_idx] <= it.loop_flag;
              ending[free_idx] <= 1'b0; ml[free_idx] <= 1'b0; mr[free_idx] <= 1'b0;
              pl[free_idx] <= '0; pr[free_idx] <= '0;
            end
          end else begin
            if (base[cur] == it.address) begin
              ending[cur] <= 1'b0;
              if (len[cur] != 0 && (pos[cur] == 0 || !it.concurrent_flag))
                blocked <= 1'b1;
            end
            if (!found && len[cur] == 0) begin
              found <= 1'b1;
              free_idx <= cur;
            end
            vi <= vi + 1'b1;
          end
        end
        ST_TICK_RD: pos[cur] <= pos_eff;
        ST_TICK_MIX: begin
          if (active) begin
            ml[cur] <= nml; mr[cur] <= nmr;
            pl[cur] <= cl; pr[cur] <= cr;
            mix_l <= mix_l + cl; mix_r <= mix_r + cr;
          end
          if (pos[cur] < POS_MAX) pos[cur] <= pos[cur] + 1'b1;
          vi <= vi + 1'b1;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_data <= '{left_out: mix_l, right_out: mix_r, buffer_end: last};
          if (last) begin
            frame_count <= '0;
            for (int j = 0; j < VOICES; j++)
              if ((ml[j] && mr[j]) || (!loopv[j] && pos[j] >= {1'b0, len[j]})) begin
                len[j] <= '0; pos[j] <= '0; ending[j] <= 1'b0;
                ml[j] <= 1'b0; mr[j] <= 1'b0; pl[j] <= '0; pr[j] <= '0;
              end
          end else frame_count <= frame_count + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pvm_checker.sv -----
// Port-level checks for the PCM voice mixer, bound to the top level.
// Depends on pvm_pkg and pcm_voice_mixer.
`timescale 1ns / 1ps
`default_nettype none
module pvm_checker
  import pvm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [2:0] in_kind,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] out_left
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left)) else $error("out");
  a_noin: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready");
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_LOAD |=> in_ready) else $error("load");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_TICK |=> !out_valid) else $error("tick");
endmodule
bind pcm_voice_mixer pvm_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.data.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_left(out_ch.data.left_out)
);
`default_nettype wire
